// ===== design/srec_pkg.sv =====
// Shared types, constants and character helpers for the S-record emitter.
// Depends on nothing; every other design file imports it.
`default_nettype none
package srec_pkg;

  localparam int ADDR_W     = 24;
  localparam int CNT_W      = 5;
  localparam int BUF_DEPTH  = 16;
  localparam int IDX_W      = 4;
  localparam int JOBQ_DEPTH = 2;
  localparam int JOBQ_PTR_W = $clog2(JOBQ_DEPTH);
  localparam int PADDR_W    = 3;
  localparam int HDR_LEN    = 11;
  localparam int TRL_LEN    = 9;

  localparam logic REG_IDX_OUTPUT_ENABLE = 1'b0;

  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_2  = 8'h32;
  localparam logic [7:0] CH_NL = 8'h0A;

  typedef enum logic [1:0] {
    CMD_DATA  = 2'd0,
    CMD_SYNC  = 2'd1,
    CMD_OPEN  = 2'd2,
    CMD_CLOSE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    JOB_RECORD,
    JOB_HEADER,
    JOB_TRAILER,
    JOB_RECORD_TRAILER
  } job_kind_t;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_S,
    PH_TYPE,
    PH_CNT,
    PH_ADDR,
    PH_DATA,
    PH_CHK,
    PH_NL,
    PH_TEXT
  } phase_t;

  typedef struct packed {
    cmd_t              command;
    logic [7:0]        data_byte;
    logic              first_of_statement;
    logic [ADDR_W-1:0] line_address;
  } srec_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_char;
  } srec_out_t;

  typedef struct packed {
    job_kind_t         kind;
    logic              bank;
    logic [CNT_W-1:0]  count;
    logic              wide;
    logic [ADDR_W-1:0] address;
    logic [7:0]        reclen;
    logic [7:0]        chk;
  } job_t;

  typedef struct packed {
    logic             en;
    logic             bank;
    logic [IDX_W-1:0] idx;
    logic [7:0]       data;
  } bufwr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } release_t;

  function automatic logic [7:0] hex_char(input logic [3:0] v);
    logic [7:0] wide_v;
    wide_v = {4'h0, v};
    return (v > 4'd9) ? wide_v + 8'd55 : wide_v + 8'd48;
  endfunction

  // "S0030000FC" followed by a newline.
  function automatic logic [7:0] hdr_char(input logic [IDX_W-1:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h53;
      4'd1:    c = 8'h30;
      4'd2:    c = 8'h30;
      4'd3:    c = 8'h33;
      4'd4:    c = 8'h30;
      4'd5:    c = 8'h30;
      4'd6:    c = 8'h30;
      4'd7:    c = 8'h30;
      4'd8:    c = 8'h46;
      4'd9:    c = 8'h43;
      default: c = CH_NL;
    endcase
    return c;
  endfunction

  // "S9020000" followed by a newline.
  function automatic logic [7:0] trl_char(input logic [IDX_W-1:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h53;
      4'd1:    c = 8'h39;
      4'd2:    c = 8'h30;
      4'd3:    c = 8'h32;
      4'd4:    c = 8'h30;
      4'd5:    c = 8'h30;
      4'd6:    c = 8'h30;
      4'd7:    c = 8'h30;
      default: c = CH_NL;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== design/srec_front.sv =====
// Front end: takes input beats, keeps the open record state and issues jobs.
// Depends on srec_pkg.
`default_nettype none
module srec_front #(
  parameter int RECORD_BYTES = 16
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                output_enable,
  input  wire                push,
  input  srec_pkg::srec_in_t item,
  output logic               full,
  output srec_pkg::job_t     job,
  output logic               job_push,
  input  wire                job_full,
  output srec_pkg::bufwr_t   bufwr,
  input  srec_pkg::release_t rel
);
  import srec_pkg::*;

  localparam logic [CNT_W-1:0] REC_LIM = CNT_W'(RECORD_BYTES);

  logic [CNT_W-1:0]  byte_count, byte_count_next;
  logic [ADDR_W-1:0] record_address, record_address_next;
  logic [7:0]        checksum_sum, checksum_sum_next;
  logic [ADDR_W-1:0] statement_offset, statement_offset_next;
  logic              wbank, wbank_next;
  logic [1:0]        bank_busy, bank_busy_next;

  logic              act;
  logic [ADDR_W-1:0] off_base, off_new;
  logic [7:0]        sum_new;
  logic [CNT_W-1:0]  cnt_new;
  logic [CNT_W-1:0]  fl_cnt;
  logic [7:0]        fl_sum;
  logic [7:0]        addr_sum;
  logic              wide;
  logic              flip;

  assign full = job_full || bank_busy[wbank];
  assign act  = push && !full && output_enable;

  always_comb begin
    off_base = item.first_of_statement ? '0 : statement_offset;
    off_new  = off_base + ADDR_W'(1);
    sum_new  = checksum_sum + item.data_byte;
    cnt_new  = byte_count + CNT_W'(1);
    wide     = |record_address[ADDR_W-1:16];
    addr_sum = record_address[23:16] + record_address[15:8] + record_address[7:0];

    // Data beats flush with their own byte included; sync and close flush as held.
    fl_cnt = (item.command == CMD_DATA) ? cnt_new : byte_count;
    fl_sum = (item.command == CMD_DATA) ? sum_new : checksum_sum;

    job.kind    = JOB_RECORD;
    job.bank    = wbank;
    job.count   = fl_cnt;
    job.wide    = wide;
    job.address = record_address;
    job.reclen  = 8'(fl_cnt) + (wide ? 8'd4 : 8'd3);
    job.chk     = 8'hFF - (addr_sum + fl_sum + job.reclen);
    job_push    = 1'b0;
    flip        = 1'b0;

    bufwr.en   = 1'b0;
    bufwr.bank = wbank;
    bufwr.idx  = byte_count[IDX_W-1:0];
    bufwr.data = item.data_byte;

    byte_count_next       = byte_count;
    record_address_next   = record_address;
    checksum_sum_next     = checksum_sum;
    statement_offset_next = statement_offset;

    if (act) begin
      unique case (item.command)
        CMD_DATA: begin
          bufwr.en              = 1'b1;
          statement_offset_next = off_new;
          if (cnt_new >= REC_LIM) begin
            job_push            = 1'b1;
            flip                = 1'b1;
            record_address_next = item.line_address + off_new;
            checksum_sum_next   = '0;
            byte_count_next     = '0;
          end else begin
            byte_count_next   = cnt_new;
            checksum_sum_next = sum_new;
          end
        end
        CMD_SYNC: begin
          job_push            = (byte_count != '0);
          flip                = (byte_count != '0);
          record_address_next = item.line_address;
          checksum_sum_next   = '0;
          byte_count_next     = '0;
        end
        CMD_OPEN: begin
          job.kind            = JOB_HEADER;
          job_push            = 1'b1;
          record_address_next = item.line_address;
          checksum_sum_next   = '0;
          byte_count_next     = '0;
        end
        CMD_CLOSE: begin
          job.kind            = (byte_count != '0) ? JOB_RECORD_TRAILER : JOB_TRAILER;
          job_push            = 1'b1;
          flip                = (byte_count != '0);
          record_address_next = item.line_address;
          checksum_sum_next   = '0;
          byte_count_next     = '0;
        end
      endcase
    end

    wbank_next     = flip ? ~wbank : wbank;
    bank_busy_next = bank_busy;
    if (rel.en) begin
      bank_busy_next[rel.bank] = 1'b0;
    end
    if (flip) begin
      bank_busy_next[wbank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count       <= '0;
      record_address   <= '0;
      checksum_sum     <= '0;
      statement_offset <= '0;
      wbank            <= 1'b0;
      bank_busy        <= '0;
    end else begin
      byte_count       <= byte_count_next;
      record_address   <= record_address_next;
      checksum_sum     <= checksum_sum_next;
      statement_offset <= statement_offset_next;
      wbank            <= wbank_next;
      bank_busy        <= bank_busy_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/srec_jobq.sv =====
// Short job queue that decouples the front end from the character back end.
// Depends on srec_pkg.
`default_nettype none
module srec_jobq (
  input  wire             clk,
  input  wire             rst,
  input  wire             push,
  input  srec_pkg::job_t  din,
  output logic            full,
  input  wire             pop,
  output srec_pkg::job_t  dout,
  output logic            empty
);
  import srec_pkg::*;

  job_t                  slots [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [JOBQ_PTR_W:0]   fill;
  logic                  do_push, do_pop;

  assign full    = (fill == (JOBQ_PTR_W+1)'(JOBQ_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + JOBQ_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + JOBQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (JOBQ_PTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (JOBQ_PTR_W+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/srec_back.sv =====
// Back end: holds the two record banks and spells each job out as ASCII text.
// Depends on srec_pkg.
`default_nettype none
module srec_back (
  input  wire                 clk,
  input  wire                 rst,
  input  srec_pkg::bufwr_t    bufwr,
  input  srec_pkg::job_t      job,
  input  wire                 q_empty,
  output logic                q_pop,
  output srec_pkg::release_t  rel,
  output srec_pkg::srec_out_t result,
  output logic                empty,
  input  wire                 pop
);
  import srec_pkg::*;

  logic [7:0] rec_mem [2][BUF_DEPTH];

  phase_t           phase, phase_next;
  job_t             cur, cur_next;
  logic             nib, nib_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             ov, ov_next;
  logic [7:0]       oc, oc_next;
  logic             ol, ol_next;
  logic [7:0]       rd_byte;

  logic             can_emit;
  logic             emit;
  logic [7:0]       ch;
  logic             last;
  logic [7:0]       hex_byte;
  logic             is_hdr;
  logic             text_end;
  logic             data_end;

  // The byte at the next cycle's bank and index is fetched at every edge. A
  // bank is never written while a job is reading it out.
  always_ff @(posedge clk) begin
    if (bufwr.en) begin
      rec_mem[bufwr.bank][bufwr.idx] <= bufwr.data;
    end
    rd_byte <= rec_mem[cur_next.bank][idx_next];
  end

  always_comb begin
    can_emit = !ov || pop;
    is_hdr   = (cur.kind == JOB_HEADER);
    text_end = is_hdr ? (idx == IDX_W'(HDR_LEN - 1)) : (idx == IDX_W'(TRL_LEN - 1));
    data_end = ((CNT_W'(idx) + CNT_W'(1)) == cur.count);

    case (phase)
      PH_CNT:  hex_byte = cur.reclen;
      PH_ADDR: hex_byte = (idx == IDX_W'(2)) ? cur.address[23:16] :
                          (idx == IDX_W'(1)) ? cur.address[15:8] : cur.address[7:0];
      PH_DATA: hex_byte = rd_byte;
      default: hex_byte = cur.chk;
    endcase

    phase_next = phase;
    cur_next   = cur;
    nib_next   = nib;
    idx_next   = idx;
    q_pop      = 1'b0;
    rel.en     = 1'b0;
    rel.bank   = cur.bank;
    emit       = 1'b0;
    last       = 1'b0;
    ch         = hex_char(nib ? hex_byte[3:0] : hex_byte[7:4]);

    unique case (phase)
      PH_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          cur_next = job;
          idx_next = '0;
          nib_next = 1'b0;
          phase_next = (job.kind == JOB_HEADER || job.kind == JOB_TRAILER) ?
                       PH_TEXT : PH_S;
        end
      end
      PH_S: begin
        ch = CH_S;
        if (can_emit) begin
          emit       = 1'b1;
          phase_next = PH_TYPE;
        end
      end
      PH_TYPE: begin
        ch = cur.wide ? CH_2 : CH_1;
        if (can_emit) begin
          emit       = 1'b1;
          nib_next   = 1'b0;
          phase_next = PH_CNT;
        end
      end
      PH_CNT: begin
        if (can_emit) begin
          emit     = 1'b1;
          nib_next = ~nib;
          if (nib) begin
            idx_next   = cur.wide ? IDX_W'(2) : IDX_W'(1);
            phase_next = PH_ADDR;
          end
        end
      end
      PH_ADDR: begin
        if (can_emit) begin
          emit     = 1'b1;
          nib_next = ~nib;
          if (nib) begin
            if (idx == '0) begin
              phase_next = PH_DATA;
            end else begin
              idx_next = idx - IDX_W'(1);
            end
          end
        end
      end
      PH_DATA: begin
        if (can_emit) begin
          emit     = 1'b1;
          nib_next = ~nib;
          if (nib) begin
            if (data_end) begin
              // The last data byte is now in the output register; hand the bank back.
              rel.en     = 1'b1;
              phase_next = PH_CHK;
            end else begin
              idx_next = idx + IDX_W'(1);
            end
          end
        end
      end
      PH_CHK: begin
        if (can_emit) begin
          emit     = 1'b1;
          nib_next = ~nib;
          if (nib) begin
            phase_next = PH_NL;
          end
        end
      end
      PH_NL: begin
        ch   = CH_NL;
        last = (cur.kind == JOB_RECORD);
        if (can_emit) begin
          emit     = 1'b1;
          idx_next = '0;
          phase_next = (cur.kind == JOB_RECORD_TRAILER) ? PH_TEXT : PH_IDLE;
        end
      end
      PH_TEXT: begin
        ch   = is_hdr ? hdr_char(idx) : trl_char(idx);
        last = text_end;
        if (can_emit) begin
          emit = 1'b1;
          if (text_end) begin
            phase_next = PH_IDLE;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase

    ov_next = ov;
    oc_next = oc;
    ol_next = ol;
    if (emit) begin
      ov_next = 1'b1;
      oc_next = ch;
      ol_next = last;
    end else if (pop) begin
      ov_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      ov    <= 1'b0;
    end else begin
      phase <= phase_next;
      ov    <= ov_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
    nib <= nib_next;
    idx <= idx_next;
    oc  <= oc_next;
    ol  <= ol_next;
  end

  assign empty           = !ov;
  assign result.out_char  = oc;
  assign result.last_char = ol;

endmodule
`default_nettype wire

// ===== design/srecord_object_emitter.sv =====
// Top level of the S-record emitter: configuration register, front end,
// job queue and character back end. Depends on srec_pkg and the srec_* modules.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ---------------------------------------
//   input     push / full            item   (command, data_byte, flags, address)
//   result    pop / empty            result (out_char, last_char)
//   config    psel/penable/pready    paddr, pwdata, pwrite, prdata
//
// The front end takes one input beat per cycle while full is low and updates
// the open record in that same cycle. A flush becomes a job in a two-entry
// queue; the back end sends one character per cycle as long as results are
// popped. A record of n data bytes is 2n+11 characters (S1) or 2n+13 (S2),
// the header 11 and the trailer 9. Each job is loaded from the queue before
// its first character is sent, and a trailer behind a flushed record shares
// that record's job. Two record banks let the front end fill the next record
// while the back end reads out the previous one; full rises while the current
// bank is still being read out or the queue is full.
// Reset is synchronous and needs no clearing pass: output is enabled and the
// record is empty. A stalled result holds in the output register.
`default_nettype none
module srecord_object_emitter #(
  parameter int RECORD_BYTES = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          push,
  output logic                         full,
  input  srec_pkg::srec_in_t           item,
  output logic                         empty,
  input  wire                          pop,
  output srec_pkg::srec_out_t          result,
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire [srec_pkg::PADDR_W-1:0]  paddr,
  input  wire [31:0]                   pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import srec_pkg::*;

  logic     output_enable;
  logic     reg_sel;
  job_t     fq_job, qb_job;
  logic     fq_push, q_full, q_empty, q_pop;
  bufwr_t   bufwr;
  release_t rel;

  // Only bit 2 of the address picks a register; the low bits are byte lanes.
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1] == REG_IDX_OUTPUT_ENABLE);
  assign prdata  = reg_sel ? {31'b0, output_enable} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_enable <= 1'b1;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      output_enable <= pwdata[0];
    end
  end

  // While output is disabled the front end still takes beats but drops them.
  srec_front #(
    .RECORD_BYTES(RECORD_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .output_enable (output_enable),
    .push          (push),
    .item          (item),
    .full          (full),
    .job           (fq_job),
    .job_push      (fq_push),
    .job_full      (q_full),
    .bufwr         (bufwr),
    .rel           (rel)
  );

  srec_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .din   (fq_job),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (qb_job),
    .empty (q_empty)
  );

  // The back end owns the record banks and releases a bank once its last
  // data byte has been turned into text.
  srec_back u_back (
    .clk     (clk),
    .rst     (rst),
    .bufwr   (bufwr),
    .job     (qb_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .rel     (rel),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
`default_nettype wire
